// File: src/hrbr_pkg.sv
// ----------------------------------------------------------------------------
// hrbr_pkg
// Shared widths, reset values, codes, payload types and the direction
// classifier of the rollback brake ramp.
// ----------------------------------------------------------------------------
package hrbr_pkg;

   localparam int HALL_W     = 3;
   localparam int VEL_W      = 16;
   localparam int TIME_W     = 32;
   localparam int THR_W      = 15;
   localparam int INTERVAL_W = 16;
   localparam int STEP_W     = 6;
   localparam int DUTY_W     = 8;
   localparam int CSR_DATA_W = 16;
   localparam int HIST_DEPTH = 4;

   localparam logic [THR_W-1:0]      THR_RESET      = THR_W'(80);
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(100);
   localparam logic [STEP_W-1:0]     STEP_RESET     = STEP_W'(5);
   localparam logic [DUTY_W-1:0]     DUTY_MAX_RESET = DUTY_W'(100);

   typedef enum logic [1:0] {
      CSR_VEL_THRESHOLD = 2'd0,
      CSR_INTERVAL_MS   = 2'd1,
      CSR_DUTY_STEP     = 2'd2,
      CSR_DUTY_MAX      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_BACK = 2'd1,
      DIR_GO   = 2'd2
   } dir_type;

   typedef enum logic {
      CMD_CAPTURE   = 1'b0,
      CMD_EMERGENCY = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [THR_W-1:0]      velocity_threshold;
      logic [INTERVAL_W-1:0] interval_ms;
      logic [STEP_W-1:0]     duty_step;
      logic [DUTY_W-1:0]     duty_max;
   } cfg_type;

   typedef struct packed {
      cmd_type                  cmd;
      logic [HALL_W-1:0]        hall_code;
      logic                     timer_started;
      logic signed [VEL_W-1:0]  measured_velocity;
      logic [TIME_W-1:0]        now_ms;
   } req_item_type;

   typedef struct packed {
      dir_type             direction_out;
      logic [DUTY_W-1:0]   duty_out;
      logic                pins_updated;
      logic                dir_pin_a;
      logic                dir_pin_b;
   } rsp_item_type;

   // Direction from the differences of four successive hall codes.
   function automatic dir_type hrbr_classify(input logic [HALL_W-1:0] h0,
                                             input logic [HALL_W-1:0] h1,
                                             input logic [HALL_W-1:0] h2,
                                             input logic [HALL_W-1:0] h3);
      logic signed [HALL_W:0] d01;
      logic signed [HALL_W:0] d12;
      logic signed [HALL_W:0] d23;
      logic                   back;
      logic                   go;
      d01  = signed'({1'b0, h0}) - signed'({1'b0, h1});
      d12  = signed'({1'b0, h1}) - signed'({1'b0, h2});
      d23  = signed'({1'b0, h2}) - signed'({1'b0, h3});
      back = (d01 == -4'sd1 && d23 == -4'sd1) || (d01 == -4'sd2 && d23 == -4'sd2) ||
             (d01 == 4'sd3 && d23 == 4'sd3) ||
             d12 == -4'sd2 || d12 == 4'sd3 || d12 == -4'sd1;
      go   = (d01 == 4'sd1 && d23 == 4'sd1) || (d01 == 4'sd2 && d23 == 4'sd2) ||
             (d01 == -4'sd3 && d23 == -4'sd3) ||
             d12 == 4'sd2 || d12 == -4'sd3 || d12 == 4'sd1;
      if (back) begin
         return DIR_BACK;
      end else if (go) begin
         return DIR_GO;
      end
      return DIR_NONE;
   endfunction

endpackage

// File: src/hrbr_req_if.sv
// ----------------------------------------------------------------------------
// hrbr_req_if
// Sample channel: hall code, velocity and timestamp beats.
// ----------------------------------------------------------------------------
interface hrbr_req_if;
   import hrbr_pkg::*;

   logic                    valid;
   logic                    ready;
   cmd_type                 cmd;
   logic [HALL_W-1:0]       hall_code;
   logic                    timer_started;
   logic signed [VEL_W-1:0] measured_velocity;
   logic [TIME_W-1:0]       now_ms;

   modport source (output valid, cmd, hall_code, timer_started, measured_velocity,
                   now_ms, input ready);
   modport sink   (input valid, cmd, hall_code, timer_started, measured_velocity,
                   now_ms, output ready);
endinterface

// File: src/hrbr_rsp_if.sv
// ----------------------------------------------------------------------------
// hrbr_rsp_if
// Result channel: direction, duty and pin levels, one beat per sample.
// ----------------------------------------------------------------------------
interface hrbr_rsp_if;
   import hrbr_pkg::*;

   logic              valid;
   logic              ready;
   dir_type           direction_out;
   logic [DUTY_W-1:0] duty_out;
   logic              pins_updated;
   logic              dir_pin_a;
   logic              dir_pin_b;

   modport source (output valid, direction_out, duty_out, pins_updated, dir_pin_a,
                   dir_pin_b, input ready);
   modport sink   (input valid, direction_out, duty_out, pins_updated, dir_pin_a,
                   dir_pin_b, output ready);
endinterface

// File: src/hrbr_csr_if.sv
// ----------------------------------------------------------------------------
// hrbr_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface hrbr_csr_if;
   import hrbr_pkg::*;

   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/hrbr_csr.sv
// ----------------------------------------------------------------------------
// hrbr_csr
// Configuration registers; writes are always taken.
// ----------------------------------------------------------------------------
module hrbr_csr (
   input  logic            clock,
   input  logic            reset,
   hrbr_csr_if.sink        csr_chan,
   output hrbr_pkg::cfg_type cfg
);
   import hrbr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_VEL_THRESHOLD: cfg_in.velocity_threshold = csr_chan.data[THR_W-1:0];
            CSR_INTERVAL_MS:   cfg_in.interval_ms        = csr_chan.data[INTERVAL_W-1:0];
            CSR_DUTY_STEP:     cfg_in.duty_step          = csr_chan.data[STEP_W-1:0];
            CSR_DUTY_MAX:      cfg_in.duty_max           = csr_chan.data[DUTY_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.velocity_threshold <= THR_RESET;
         cfg_ff.interval_ms        <= INTERVAL_RESET;
         cfg_ff.duty_step          <= STEP_RESET;
         cfg_ff.duty_max           <= DUTY_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/hrbr_engine.sv
// ----------------------------------------------------------------------------
// hrbr_engine
// Hall history, direction and duty state; computes one result per fired
// sample and updates the state in the same cycle.
// ----------------------------------------------------------------------------
module hrbr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  hrbr_pkg::req_item_type item,
   input  hrbr_pkg::cfg_type      cfg,
   output hrbr_pkg::rsp_item_type result
);
   import hrbr_pkg::*;

   logic [HALL_W-1:0] hist_ff [HIST_DEPTH];
   logic [HALL_W-1:0] hist_in [HIST_DEPTH];
   logic              armed_ff, armed_in;
   dir_type           dir_ff, dir_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic [TIME_W-1:0] last_ff, last_in;

   logic signed [VEL_W:0]   vel_ext;
   logic signed [VEL_W:0]   thr_ext;
   logic                    vel_act;
   logic                    vel_pos;
   logic                    vel_neg;
   logic                    elapsed;
   logic [TIME_W-1:0]       since;
   dir_type                 cls;
   logic [DUTY_W:0]         up_sum;
   logic [DUTY_W-1:0]       duty_up;
   logic [DUTY_W-1:0]       duty_down;
   logic                    pins;
   logic                    pin_a;
   logic                    pin_b;

   assign vel_ext = signed'({item.measured_velocity[VEL_W-1], item.measured_velocity});
   assign thr_ext = signed'({2'b00, cfg.velocity_threshold});
   assign vel_act = (vel_ext <= -thr_ext) || (vel_ext >= thr_ext);
   assign vel_neg = item.measured_velocity[VEL_W-1];
   assign vel_pos = !vel_neg && (item.measured_velocity != '0);

   assign since   = item.now_ms - last_ff;
   assign elapsed = since >= {{(TIME_W-INTERVAL_W){1'b0}}, cfg.interval_ms};

   // Classification sees the fourth code as the one being stored now.
   assign cls = hrbr_classify(hist_ff[0], hist_ff[1], hist_ff[2], item.hall_code);

   // Saturating ramp in both directions.
   assign up_sum = {1'b0, duty_ff} + {{(DUTY_W+1-STEP_W){1'b0}}, cfg.duty_step};
   always_comb begin
      duty_up = duty_ff;
      if (duty_ff < cfg.duty_max) begin
         duty_up = (up_sum > {1'b0, cfg.duty_max}) ? cfg.duty_max : up_sum[DUTY_W-1:0];
      end
      duty_down = duty_ff;
      if (duty_ff != '0) begin
         duty_down = (duty_ff > {{(DUTY_W-STEP_W){1'b0}}, cfg.duty_step})
                   ? duty_ff - {{(DUTY_W-STEP_W){1'b0}}, cfg.duty_step} : '0;
      end
   end

   always_comb begin
      hist_in  = hist_ff;
      armed_in = armed_ff;
      dir_in   = dir_ff;
      duty_in  = duty_ff;
      last_in  = last_ff;
      pins     = 1'b0;
      pin_a    = 1'b0;
      pin_b    = 1'b0;
      if (fire) begin
         if (item.cmd == CMD_CAPTURE) begin
            if (armed_ff && item.timer_started) begin
               hist_in[0] = item.hall_code;
               armed_in   = 1'b0;
            end
         end else if (vel_act) begin
            priority if (hist_ff[0] != item.hall_code && hist_ff[1] == '0) begin
               hist_in[1] = item.hall_code;
            end else if (hist_ff[1] != item.hall_code && hist_ff[1] != '0 &&
                         hist_ff[2] == '0) begin
               hist_in[2] = item.hall_code;
            end else if (hist_ff[2] != item.hall_code && hist_ff[1] != '0 &&
                         hist_ff[2] != '0 && hist_ff[3] == '0) begin
               hist_in[3] = item.hall_code;
               if (cls != DIR_NONE) begin
                  dir_in = cls;
               end
            end else begin
               hist_in = hist_ff;
            end

            if (elapsed) begin
               last_in = item.now_ms;
               unique case (dir_in)
                  DIR_BACK: begin
                     pins  = 1'b1;
                     pin_b = 1'b1;
                     if (vel_pos) begin
                        duty_in = duty_up;
                     end else if (vel_neg) begin
                        duty_in = duty_down;
                     end
                  end
                  DIR_GO: begin
                     pins  = 1'b1;
                     pin_a = 1'b1;
                     if (vel_neg) begin
                        duty_in = duty_up;
                     end else if (vel_pos) begin
                        duty_in = duty_down;
                     end
                  end
                  default: begin
                     pins = 1'b0;
                  end
               endcase
            end
         end
      end
   end

   assign result.direction_out = dir_in;
   assign result.duty_out      = duty_in;
   assign result.pins_updated  = pins;
   assign result.dir_pin_a     = pin_a;
   assign result.dir_pin_b     = pin_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         armed_ff <= 1'b1;
         dir_ff   <= DIR_NONE;
         duty_ff  <= '0;
         last_ff  <= '0;
      end else begin
         hist_ff  <= hist_in;
         armed_ff <= armed_in;
         dir_ff   <= dir_in;
         duty_ff  <= duty_in;
         last_ff  <= last_in;
      end
   end

endmodule

// File: src/hall_rollback_brake_ramp_core.sv
// ----------------------------------------------------------------------------
// hall_rollback_brake_ramp_core
// Rollback brake ramp with hall-code direction detection.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock while results are taken and returns one
// result beat per sample, in order. A sample is registered on acceptance,
// evaluated against the hall history, direction and duty state once the
// output register is free or being taken, and its result is held in that
// register, from which the result beat is offered. The state is updated as
// each result is registered, so back-to-back samples are sustained at one per
// clock while the result side keeps taking beats. Register writes are taken
// at once and should only be made while no sample is in flight.
module hall_rollback_brake_ramp_core (
   input  logic       clock,
   input  logic       reset,
   hrbr_req_if.sink   req_chan,
   hrbr_rsp_if.source rsp_chan,
   hrbr_csr_if.sink   csr_chan
);
   import hrbr_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type step_result;
   logic         accept;
   logic         advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_item_in                   = in_item_ff;
      in_item_in.cmd               = req_chan.cmd;
      in_item_in.hall_code         = req_chan.hall_code;
      in_item_in.timer_started     = req_chan.timer_started;
      in_item_in.measured_velocity = req_chan.measured_velocity;
      in_item_in.now_ms            = req_chan.now_ms;
      if (!accept) begin
         in_item_in = in_item_ff;
      end
      in_valid_in  = accept || (in_valid_ff && !advance);
      out_item_in  = advance ? step_result : out_item_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   hrbr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   hrbr_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.direction_out = out_item_ff.direction_out;
   assign rsp_chan.duty_out      = out_item_ff.duty_out;
   assign rsp_chan.pins_updated  = out_item_ff.pins_updated;
   assign rsp_chan.dir_pin_a     = out_item_ff.dir_pin_a;
   assign rsp_chan.dir_pin_b     = out_item_ff.dir_pin_b;

endmodule

// File: src/hrbr_checker.sv
// ----------------------------------------------------------------------------
// hrbr_checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module hrbr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input hrbr_pkg::dir_type direction_out,
   input logic [7:0]        duty_out,
   input logic              pins_updated,
   input logic              dir_pin_a,
   input logic              dir_pin_b
);
   import hrbr_pkg::*;

   // A stalled beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty_out) &&
      $stable(direction_out) && $stable(pins_updated))
      else $error("result beat changed while stalled");

   // Driven pins are complementary and agree with the reported direction.
   a_pins_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pins_updated |->
      (dir_pin_a != dir_pin_b) &&
      ((dir_pin_a && direction_out == DIR_GO) || (dir_pin_b && direction_out == DIR_BACK)))
      else $error("driven pins disagree with direction");

   // Undriven pins read low.
   a_pins_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pins_updated |-> !dir_pin_a && !dir_pin_b)
      else $error("pin level without pin update");

   // Nothing leaves the block straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind hall_rollback_brake_ramp_core hrbr_checker u_hrbr_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .direction_out (rsp_chan.direction_out),
   .duty_out      (rsp_chan.duty_out),
   .pins_updated  (rsp_chan.pins_updated),
   .dir_pin_a     (rsp_chan.dir_pin_a),
   .dir_pin_b     (rsp_chan.dir_pin_b)
);

// File: tb/sv/hall_rollback_brake_ramp_checker.sv
// ----------------------------------------------------------------------------
// hall_rollback_brake_ramp_checker
// Watches the sample, result and register channels of the rollback brake
// ramp, predicts each result from its own copy of the hall history,
// direction and duty state, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module hall_rollback_brake_ramp_checker (
   input  logic clock,
   input  logic reset,
   hrbr_req_if  req_mon,
   hrbr_rsp_if  rsp_mon,
   hrbr_csr_if  csr_mon,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import hrbr_pkg::*;

   logic [THR_W-1:0]      thr_r;
   logic [INTERVAL_W-1:0] interval_r;
   logic [STEP_W-1:0]     step_r;
   logic [DUTY_W-1:0]     duty_max_r;

   logic [HALL_W-1:0]     hist [HIST_DEPTH];
   logic                  armed;
   logic                  decided;
   dir_type               dir_r;
   logic [DUTY_W-1:0]     duty_r;
   logic [TIME_W-1:0]     last_adjust;

   rsp_item_type          rsp_due_q [$];

   // Direction from successive hall code differences; back wins when both match, none when neither does.
   function automatic dir_type hall_rotation();
      int d01;
      int d12;
      int d23;
      d01 = int'(hist[0]) - int'(hist[1]);
      d12 = int'(hist[1]) - int'(hist[2]);
      d23 = int'(hist[2]) - int'(hist[3]);
      if ((d01 == -1 && d23 == -1) || (d01 == -2 && d23 == -2) ||
          (d01 == 3 && d23 == 3) || d12 == -2 || d12 == 3 || d12 == -1) begin
         return DIR_BACK;
      end
      if ((d01 == 1 && d23 == 1) || (d01 == 2 && d23 == 2) ||
          (d01 == -3 && d23 == -3) || d12 == 2 || d12 == -3 || d12 == 1) begin
         return DIR_GO;
      end
      return DIR_NONE;
   endfunction

   function automatic void duty_raise();
      logic [DUTY_W:0] sum;
      if (duty_r < duty_max_r) begin
         sum    = {1'b0, duty_r} + step_r;
         duty_r = (sum > duty_max_r) ? duty_max_r : sum[DUTY_W-1:0];
      end
   endfunction

   function automatic void duty_lower();
      if (duty_r != '0) begin
         duty_r = (duty_r > step_r) ? duty_r - step_r : '0;
      end
   endfunction

   function automatic rsp_item_type brake_predict(input cmd_type           cmd,
                                                  input logic [HALL_W-1:0] hall,
                                                  input logic              started,
                                                  input logic signed [VEL_W-1:0] vel,
                                                  input logic [TIME_W-1:0] now);
      rsp_item_type     res;
      dir_type          found;
      int               v;
      int               t;
      logic [TIME_W-1:0] gap;
      res = '0;
      v   = vel;
      t   = int'(thr_r);
      if (cmd == CMD_CAPTURE) begin
         if (armed && started) begin
            hist[0] = hall;
            armed   = 1'b0;
         end
      end else if (v <= -t || v >= t) begin
         if (hist[0] != hall && hist[1] == '0) begin
            hist[1] = hall;
         end else if (hist[1] != hall && hist[1] != '0 && hist[2] == '0) begin
            hist[2] = hall;
         end else if (hist[2] != hall && hist[1] != '0 && hist[2] != '0 &&
                      hist[3] == '0) begin
            hist[3] = hall;
            decided = 1'b0;
         end
         if (!decided) begin
            found = hall_rotation();
            if (found != DIR_NONE) begin
               dir_r = found;
            end
            decided = 1'b1;
         end
         gap = now - last_adjust;
         if (gap >= TIME_W'(interval_r) && decided) begin
            // duty is always pushed against the motion
            if (dir_r == DIR_BACK) begin
               res.pins_updated = 1'b1;
               res.dir_pin_b    = 1'b1;
               if (v > 0) begin
                  duty_raise();
               end else if (v < 0) begin
                  duty_lower();
               end
            end else if (dir_r == DIR_GO) begin
               res.pins_updated = 1'b1;
               res.dir_pin_a    = 1'b1;
               if (v < 0) begin
                  duty_raise();
               end else if (v > 0) begin
                  duty_lower();
               end
            end
            last_adjust = now;
         end
      end
      res.direction_out = dir_r;
      res.duty_out      = duty_r;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      logic         same;
      if (reset) begin
         thr_r       = THR_RESET;
         interval_r  = INTERVAL_RESET;
         step_r      = STEP_RESET;
         duty_max_r  = DUTY_MAX_RESET;
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist[i] = '0;
         end
         armed       = 1'b1;
         decided     = 1'b1;
         dir_r       = DIR_NONE;
         duty_r      = '0;
         last_adjust = '0;
         rsp_due_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_VEL_THRESHOLD: thr_r      = csr_mon.data[THR_W-1:0];
               CSR_INTERVAL_MS:   interval_r = csr_mon.data[INTERVAL_W-1:0];
               CSR_DUTY_STEP:     step_r     = csr_mon.data[STEP_W-1:0];
               CSR_DUTY_MAX:      duty_max_r = csr_mon.data[DUTY_W-1:0];
               default: ;
            endcase
         end
         // result beat first: it can only belong to an older sample
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rsp_due_q.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: result beat with nothing outstanding: dir=%0d duty=%0d",
                           $realtime, rsp_mon.direction_out, rsp_mon.duty_out);
               end
               fail_count++;
            end else begin
               want = rsp_due_q.pop_front();
               same = (rsp_mon.direction_out === want.direction_out) &&
                      (rsp_mon.duty_out      === want.duty_out) &&
                      (rsp_mon.pins_updated  === want.pins_updated) &&
                      (rsp_mon.dir_pin_a     === want.dir_pin_a) &&
                      (rsp_mon.dir_pin_b     === want.dir_pin_b);
               if (!same) begin
                  if (fail_count < 10) begin
                     $display("%0t: mismatch exp dir=%0d duty=%0d pins=%0b a=%0b b=%0b",
                              $realtime, want.direction_out, want.duty_out,
                              want.pins_updated, want.dir_pin_a, want.dir_pin_b);
                     $display("%0t:          got dir=%0d duty=%0d pins=%0b a=%0b b=%0b",
                              $realtime, rsp_mon.direction_out, rsp_mon.duty_out,
                              rsp_mon.pins_updated, rsp_mon.dir_pin_a,
                              rsp_mon.dir_pin_b);
                  end
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rsp_due_q.push_back(brake_predict(req_mon.cmd, req_mon.hall_code,
                                              req_mon.timer_started,
                                              req_mon.measured_velocity,
                                              req_mon.now_ms));
         end
      end
      pending_count = rsp_due_q.size();
   end

endmodule

// File: tb/sv/hall_rollback_brake_ramp_core_test.sv
// ----------------------------------------------------------------------------
// hall_rollback_brake_ramp_core_test
// Drives the rollback brake ramp with a directed capture, history fill and
// ramp sequence, then random sample phases under several register settings
// and back-pressure patterns; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module hall_rollback_brake_ramp_core_test ();
   timeunit 1ns;
   timeprecision 1ps;

   import hrbr_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrbr_req_if req_chan ();
   hrbr_rsp_if rsp_chan ();
   hrbr_csr_if csr_chan ();

   int fails;
   int pending;

   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   logic hold_kick   = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;
   logic rsp_take    = 1'b0;

   int                cur_thr      = int'(THR_RESET);
   int                cur_interval = int'(INTERVAL_RESET);
   logic [TIME_W-1:0] sample_ms    = '0;

   assign rsp_chan.ready = rsp_take;

   always #6 clock = ~clock;

   hall_rollback_brake_ramp_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   hall_rollback_brake_ramp_checker i_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_mon       (csr_chan),
      .fail_count    (fails),
      .pending_count (pending)
   );

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_take  <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= 400;
         rsp_take  <= 1'b0;
      end else begin
         rsp_take <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
   end

   task automatic send_sample(input cmd_type                 c,
                              input logic [HALL_W-1:0]       h,
                              input logic                    started,
                              input logic signed [VEL_W-1:0] v,
                              input logic [TIME_W-1:0]       now);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid             <= 1'b1;
      req_chan.cmd               <= c;
      req_chan.hall_code         <= h;
      req_chan.timer_started     <= started;
      req_chan.measured_velocity <= v;
      req_chan.now_ms            <= now;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
   endtask

   // sender stops until every outstanding result has been taken
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input int value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_chan.ready) begin
         @(posedge clock);
      end
   endtask

   task automatic load_settings(input int thr, input int interval, input int step,
                                input int dmax);
      write_reg(CSR_VEL_THRESHOLD, thr);
      write_reg(CSR_INTERVAL_MS, interval);
      write_reg(CSR_DUTY_STEP, step);
      write_reg(CSR_DUTY_MAX, dmax);
      csr_chan.valid <= 1'b0;
      cur_thr      = thr;
      cur_interval = interval;
   endtask

   task automatic send_random_sample();
      int      dt;
      int      m;
      int      v;
      cmd_type c;
      if ($urandom_range(0, 99) < 5) begin
         sample_ms = $urandom;
      end else begin
         case ($urandom_range(0, 2))
            0: dt = $urandom_range(0, cur_interval / 2);
            1: dt = cur_interval + int'($urandom_range(0, 2)) - 1;
            default: dt = $urandom_range(0, 2 * cur_interval + 1);
         endcase
         if (dt < 0) begin
            dt = 0;
         end
         sample_ms = sample_ms + TIME_W'(dt);
      end
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: begin
            m = cur_thr + int'($urandom_range(0, 4)) - 2;
            v = $urandom_range(0, 1) ? -m : m;
         end
         2: v = int'($urandom_range(0, 4)) - 2;
         default: begin
            m = 32767 - int'($urandom_range(0, 100));
            v = $urandom_range(0, 1) ? -m - 1 : m;
         end
      endcase
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      c = ($urandom_range(0, 99) < 8) ? CMD_CAPTURE : CMD_EMERGENCY;
      send_sample(c, HALL_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  VEL_W'(v), sample_ms);
   endtask

   initial begin
      int h0;
      int h1;
      int h2;
      int h3;
      int waited;
      req_chan.valid             = 1'b0;
      req_chan.cmd               = CMD_CAPTURE;
      req_chan.hall_code         = '0;
      req_chan.timer_started     = 1'b0;
      req_chan.measured_velocity = '0;
      req_chan.now_ms            = '0;
      csr_chan.valid             = 1'b0;
      csr_chan.index             = CSR_VEL_THRESHOLD;
      csr_chan.data              = '0;
      repeat (10) @(posedge clock);
      reset         <= 1'b0;
      src_idle_pct  <= 13;
      sink_idle_pct <= 69;

      // history codes: h1 and h2 close enough that the middle difference decides
      h1 = $urandom_range(1, 7);
      do begin
         h2 = $urandom_range(1, 7);
      end while (h2 == h1 || h2 > h1 + 3 || h1 > h2 + 3);
      do begin
         h0 = $urandom_range(0, 7);
      end while (h0 == h1);
      if ($urandom_range(0, 3) == 0) begin
         h3 = 0;   // empty last slot lets later codes reclassify
      end else begin
         do begin
            h3 = $urandom_range(1, 7);
         end while (h3 == h2);
      end

      // capture ignored until the timer runs; sub-threshold emergencies ignored
      send_sample(CMD_CAPTURE, 3'd7, 1'b0, 16'sd0, 32'd0);
      send_sample(CMD_EMERGENCY, 3'd5, 1'b1, 16'sd79, 32'd1000);
      send_sample(CMD_EMERGENCY, 3'd3, 1'b0, -16'sd79, 32'd1000);
      send_sample(CMD_CAPTURE, HALL_W'(h0), 1'b1, 16'sd0, 32'd10);
      send_sample(CMD_CAPTURE, HALL_W'(~h0), 1'b1, 16'sd0, 32'd20);
      // interval runs out while still undecided
      send_sample(CMD_EMERGENCY, HALL_W'(h0), 1'b0, -16'sd80, 32'd150);
      send_sample(CMD_EMERGENCY, HALL_W'(h1), 1'b1, 16'sd80, 32'd200);
      send_sample(CMD_EMERGENCY, HALL_W'(h1), 1'b1, 16'sd32767, 32'd210);
      send_sample(CMD_EMERGENCY, HALL_W'(h2), 1'b0, -16'sd32768, 32'd220);
      send_sample(CMD_EMERGENCY, HALL_W'(h3), 1'b1, 16'sd200, 32'd400);
      send_sample(CMD_EMERGENCY, HALL_W'(h3), 1'b1, -16'sd200, 32'd450);
      send_sample(CMD_EMERGENCY, HALL_W'(h3), 1'b1, -16'sd200, 32'd500);
      send_sample(CMD_EMERGENCY, HALL_W'(h3), 1'b0, 16'sd0, 32'd600);
      send_sample(CMD_EMERGENCY, 3'd0, 1'b1, 16'sd32767, 32'd700);
      send_sample(CMD_EMERGENCY, 3'd7, 1'b1, 16'sd32767, 32'd800);
      send_sample(CMD_EMERGENCY, 3'd7, 1'b0, -16'sd32768, 32'd900);
      send_sample(CMD_EMERGENCY, 3'd0, 1'b1, -16'sd32768, 32'd1000);
      send_sample(CMD_EMERGENCY, HALL_W'(h2), 1'b1, 16'sd1000, 32'hFFFF_FFF0);
      // wrapped timestamp: 96 ms, then 112 ms past the last adjustment
      send_sample(CMD_EMERGENCY, HALL_W'(h2), 1'b1, -16'sd1000, 32'h0000_0050);
      send_sample(CMD_EMERGENCY, HALL_W'(h2), 1'b1, -16'sd1000, 32'h0000_0060);
      send_sample(CMD_CAPTURE, 3'd0, 1'b1, -16'sd1, 32'hFFFF_FFFF);
      sample_ms = 32'h0000_0060;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_settings($urandom_range(0, 300), $urandom_range(1, 200),
                             $urandom_range(1, 63), $urandom_range(0, 255));
            1: load_settings(0, 0, 63, 255);
            2: load_settings(32767, 65535, 1, 0);
            3: load_settings($urandom_range(0, 32767), $urandom_range(1, 65535),
                             $urandom_range(1, 63), $urandom_range(0, 255));
            4: load_settings(80, 1, 7, 255);
            default: load_settings($urandom_range(0, 500), $urandom_range(1, 50),
                                   63, $urandom_range(0, 40));
         endcase
         case (ph / 2)
            0: begin
               src_idle_pct  <= 13;
               sink_idle_pct <= 69;
            end
            1: begin
               src_idle_pct  <= 69;
               sink_idle_pct <= 13;
            end
            default: begin
               src_idle_pct  <= 0;
               sink_idle_pct <= 0;
            end
         endcase
         for (int n = 0; n < 200; n++) begin
            if (ph == 4 && n == 20) begin
               hold_kick <= ~hold_kick;
            end
            if (ph == 1 && n == 100) begin
               drain();
            end
            send_random_sample();
         end
         drain();
      end

      req_chan.valid <= 1'b0;
      waited = 0;
      @(negedge clock);
      while (pending != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (fails == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

endmodule
